// File: rtl/core/cpid_pkg.sv
package cpid_pkg;

	localparam int VALUE_WIDTH    = 32;
	localparam int GAIN_WIDTH     = 24;
	localparam int LIMIT_WIDTH    = VALUE_WIDTH - 1;
	localparam int ALPHA_WIDTH    = 17;
	localparam int GAIN_SHIFT     = 12;
	localparam int ALPHA_SHIFT    = 16;
	localparam int PROD_WIDTH     = VALUE_WIDTH + GAIN_WIDTH;
	localparam int ACC_WIDTH      = VALUE_WIDTH + 2;
	localparam int CFG_ADDR_WIDTH = 5;
	localparam int CFG_DATA_WIDTH = 32;

	localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE = ALPHA_WIDTH'(1 << ALPHA_SHIFT);

	typedef logic signed [VALUE_WIDTH-1:0] value_t;

	localparam value_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam value_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	typedef enum logic [2:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_INTEG_GAIN     = 3'd1,
		REG_DERIV_GAIN     = 3'd2,
		REG_INTEGRAL_LIMIT = 3'd3,
		REG_OUTPUT_LIMIT   = 3'd4,
		REG_DERIV_FILTER   = 3'd5,
		REG_FILTER_ALPHA   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_WIDTH-1:0]  prop_gain;
		logic [GAIN_WIDTH-1:0]  integ_gain;
		logic [GAIN_WIDTH-1:0]  deriv_gain;
		logic [LIMIT_WIDTH-1:0] integral_limit;
		logic [LIMIT_WIDTH-1:0] output_limit;
		logic                   deriv_filter_on;
		logic [ALPHA_WIDTH-1:0] filter_alpha;
	} cfg_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_PROP,
		MUL_INTEG,
		MUL_DERIV,
		MUL_ALPHA_NEW,
		MUL_ALPHA_OLD
	} mul_op_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_ADD,
		ACC_DTERM,
		ACC_FILT,
		ACC_ADD_DTERM
	} acc_op_t;

	typedef struct packed {
		logic    capture;
		logic    do_err;
		logic    do_integ;
		mul_op_t mul_op;
		acc_op_t acc_op;
		logic    fin;
	} cmd_t;

	function automatic value_t sat_one(input logic [VALUE_WIDTH:0] v);
		if (v[VALUE_WIDTH] != v[VALUE_WIDTH-1]) begin
			return v[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
		end
		return value_t'(v[VALUE_WIDTH-1:0]);
	endfunction

	function automatic value_t sat_acc(input logic [ACC_WIDTH-1:0] v);
		if ((&v[ACC_WIDTH-1:VALUE_WIDTH-1]) || !(|v[ACC_WIDTH-1:VALUE_WIDTH-1])) begin
			return value_t'(v[VALUE_WIDTH-1:0]);
		end
		return v[ACC_WIDTH-1] ? VAL_MIN : VAL_MAX;
	endfunction

endpackage

// File: rtl/core/cpid_cfg.sv
module cpid_cfg
	import cpid_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [CFG_DATA_WIDTH-1:0] pwdata,
	output logic [CFG_DATA_WIDTH-1:0] prdata,
	output logic                      pready,
	output cfg_t                      cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[CFG_ADDR_WIDTH-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_PROP_GAIN:      cfg_q.prop_gain       <= pwdata[GAIN_WIDTH-1:0];
				REG_INTEG_GAIN:     cfg_q.integ_gain      <= pwdata[GAIN_WIDTH-1:0];
				REG_DERIV_GAIN:     cfg_q.deriv_gain      <= pwdata[GAIN_WIDTH-1:0];
				REG_INTEGRAL_LIMIT: cfg_q.integral_limit  <= pwdata[LIMIT_WIDTH-1:0];
				REG_OUTPUT_LIMIT:   cfg_q.output_limit    <= pwdata[LIMIT_WIDTH-1:0];
				REG_DERIV_FILTER:   cfg_q.deriv_filter_on <= pwdata[0];
				REG_FILTER_ALPHA:   cfg_q.filter_alpha    <= pwdata[ALPHA_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_PROP_GAIN:      prdata = CFG_DATA_WIDTH'(cfg_q.prop_gain);
			REG_INTEG_GAIN:     prdata = CFG_DATA_WIDTH'(cfg_q.integ_gain);
			REG_DERIV_GAIN:     prdata = CFG_DATA_WIDTH'(cfg_q.deriv_gain);
			REG_INTEGRAL_LIMIT: prdata = CFG_DATA_WIDTH'(cfg_q.integral_limit);
			REG_OUTPUT_LIMIT:   prdata = CFG_DATA_WIDTH'(cfg_q.output_limit);
			REG_DERIV_FILTER:   prdata = CFG_DATA_WIDTH'(cfg_q.deriv_filter_on);
			REG_FILTER_ALPHA:   prdata = CFG_DATA_WIDTH'(cfg_q.filter_alpha);
			default:            prdata = '0;
		endcase
	end

endmodule

// File: rtl/core/cpid_dp.sv
module cpid_dp
	import cpid_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  cmd_t   cmd,
	input  value_t target,
	input  value_t measured,
	input  logic   clear_history,
	output value_t drive,
	output logic   output_saturated
);

	value_t target_q;
	value_t measured_q;
	logic   clear_q;
	value_t err_q;
	value_t diff_q;
	value_t integ_q;
	value_t prev_err_q;
	value_t prev_dterm_q;
	value_t dterm_q;
	value_t term_q;
	value_t drive_q;
	logic   osat_q;
	logic [ACC_WIDTH-1:0]  acc_q;
	logic [PROD_WIDTH-1:0] prod_s1;
	logic                  neg_s1;
	logic                  shift16_s1;

	value_t                  op_val;
	logic [GAIN_WIDTH-1:0]   weight;
	logic                    shift16;
	logic [VALUE_WIDTH-1:0]  mag;
	logic [ALPHA_WIDTH-1:0]  alpha_eff;
	logic [ALPHA_WIDTH-1:0]  alpha_rest;
	logic [PROD_WIDTH-1:0]   shifted;
	logic [VALUE_WIDTH-1:0]  mag_lim;
	logic [VALUE_WIDTH-1:0]  mag_cap;
	value_t                  term_next;
	value_t                  err_next;
	value_t                  isum;
	value_t                  ilim;
	value_t                  nilim;
	value_t                  ihigh;
	value_t                  integ_next;
	value_t                  diff_next;
	value_t                  filt_sum;
	value_t                  acc_sat;
	value_t                  olim;
	value_t                  drive_next;
	logic                    osat_next;

	assign drive            = drive_q;
	assign output_saturated = osat_q;

	assign err_next  = sat_one({target_q[VALUE_WIDTH-1], target_q}
		- {measured_q[VALUE_WIDTH-1], measured_q});
	assign isum      = sat_one({integ_q[VALUE_WIDTH-1], integ_q} + {err_q[VALUE_WIDTH-1], err_q});
	assign ilim      = $signed({1'b0, cfg.integral_limit});
	assign nilim     = -ilim;
	assign ihigh     = (isum >= ilim) ? ilim : isum;
	assign integ_next = (ihigh <= nilim) ? nilim : ihigh;
	assign diff_next = sat_one({err_q[VALUE_WIDTH-1], err_q}
		- {prev_err_q[VALUE_WIDTH-1], prev_err_q});
	assign filt_sum  = sat_one({dterm_q[VALUE_WIDTH-1], dterm_q} + {term_q[VALUE_WIDTH-1], term_q});

	assign alpha_eff  = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
	assign alpha_rest = ALPHA_ONE - alpha_eff;

	always_comb begin
		op_val  = '0;
		weight  = '0;
		shift16 = 1'b0;
		unique case (cmd.mul_op)
			MUL_NONE: begin
				op_val = '0;
				weight = '0;
			end
			MUL_PROP: begin
				op_val = err_q;
				weight = cfg.prop_gain;
			end
			MUL_INTEG: begin
				op_val = integ_q;
				weight = cfg.integ_gain;
			end
			MUL_DERIV: begin
				op_val = diff_q;
				weight = cfg.deriv_gain;
			end
			MUL_ALPHA_NEW: begin
				op_val  = term_q;
				weight  = GAIN_WIDTH'(alpha_rest);
				shift16 = 1'b1;
			end
			MUL_ALPHA_OLD: begin
				op_val  = prev_dterm_q;
				weight  = GAIN_WIDTH'(alpha_eff);
				shift16 = 1'b1;
			end
			default: begin
				op_val = '0;
				weight = '0;
			end
		endcase
	end

	assign mag = op_val[VALUE_WIDTH-1] ? (~op_val + 1'b1) : op_val;

	// The magnitude is truncated, capped and then given its sign back.
	assign shifted = shift16_s1 ? (prod_s1 >> ALPHA_SHIFT) : (prod_s1 >> GAIN_SHIFT);
	assign mag_lim = neg_s1 ? {1'b1, {(VALUE_WIDTH-1){1'b0}}} : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	assign mag_cap = ((|shifted[PROD_WIDTH-1:VALUE_WIDTH]) || (shifted[VALUE_WIDTH-1:0] > mag_lim))
		? mag_lim : shifted[VALUE_WIDTH-1:0];
	assign term_next = neg_s1 ? value_t'(~mag_cap + 1'b1) : value_t'(mag_cap);

	assign acc_sat = sat_acc(acc_q);
	assign olim    = $signed({1'b0, cfg.output_limit});

	always_comb begin
		drive_next = acc_sat;
		osat_next  = 1'b0;
		if (acc_sat > olim) begin
			drive_next = olim;
			osat_next  = 1'b1;
		end else if (acc_sat < -olim) begin
			drive_next = -olim;
			osat_next  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q      <= '0;
			prev_err_q   <= '0;
			prev_dterm_q <= '0;
		end else begin
			if (cmd.do_err && clear_q) begin
				integ_q    <= '0;
				prev_err_q <= '0;
			end
			if (cmd.do_integ) begin
				integ_q    <= integ_next;
				prev_err_q <= err_q;
			end
			if (cmd.acc_op == ACC_FILT) begin
				prev_dterm_q <= filt_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1    <= PROD_WIDTH'(mag) * PROD_WIDTH'(weight);
		neg_s1     <= op_val[VALUE_WIDTH-1];
		shift16_s1 <= shift16;
		term_q     <= term_next;
		if (cmd.capture) begin
			target_q   <= target;
			measured_q <= measured;
			clear_q    <= clear_history;
		end
		if (cmd.do_err) begin
			err_q <= err_next;
		end
		if (cmd.do_integ) begin
			diff_q <= diff_next;
		end
		unique case (cmd.acc_op)
			ACC_NONE:      ;
			ACC_LOAD:      acc_q   <= ACC_WIDTH'(term_q);
			ACC_ADD:       acc_q   <= acc_q + ACC_WIDTH'(term_q);
			ACC_DTERM:     dterm_q <= term_q;
			ACC_FILT:      dterm_q <= filt_sum;
			ACC_ADD_DTERM: acc_q   <= acc_q + ACC_WIDTH'(dterm_q);
			default:       ;
		endcase
		if (cmd.fin) begin
			drive_q <= drive_next;
			osat_q  <= osat_next;
		end
	end

endmodule

// File: rtl/core/cpid_ctrl.sv
module cpid_ctrl
	import cpid_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  logic filter_on,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_INTEG,
		ST_MUL_D,
		ST_MUL_I,
		ST_PLAIN_D,
		ST_PLAIN_I,
		ST_FILT_A,
		ST_FILT_B,
		ST_FILT_SUM_A,
		ST_FILT_SUM_B,
		ST_FILT_ADD,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   fin_go;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign fin_go    = !out_valid_q || !out_stall;

	always_comb begin
		cmd         = '0;
		cmd.mul_op  = MUL_NONE;
		cmd.acc_op  = ACC_NONE;
		unique case (state_q)
			ST_IDLE:       cmd.capture = in_valid;
			ST_ERR:        cmd.do_err = 1'b1;
			ST_INTEG: begin
				cmd.do_integ = 1'b1;
				cmd.mul_op   = MUL_PROP;
			end
			ST_MUL_D:      cmd.mul_op = MUL_DERIV;
			ST_MUL_I: begin
				cmd.mul_op = MUL_INTEG;
				cmd.acc_op = ACC_LOAD;
			end
			ST_PLAIN_D:    cmd.acc_op = ACC_ADD;
			ST_PLAIN_I:    cmd.acc_op = ACC_ADD;
			ST_FILT_A:     cmd.mul_op = MUL_ALPHA_NEW;
			ST_FILT_B: begin
				cmd.mul_op = MUL_ALPHA_OLD;
				cmd.acc_op = ACC_ADD;
			end
			ST_FILT_SUM_A: cmd.acc_op = ACC_DTERM;
			ST_FILT_SUM_B: cmd.acc_op = ACC_FILT;
			ST_FILT_ADD:   cmd.acc_op = ACC_ADD_DTERM;
			ST_FIN:        cmd.fin = fin_go;
			default:       cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR:        state_q <= ST_INTEG;
				ST_INTEG:      state_q <= ST_MUL_D;
				ST_MUL_D:      state_q <= ST_MUL_I;
				ST_MUL_I:      state_q <= filter_on ? ST_FILT_A : ST_PLAIN_D;
				ST_PLAIN_D:    state_q <= ST_PLAIN_I;
				ST_PLAIN_I:    state_q <= ST_FIN;
				ST_FILT_A:     state_q <= ST_FILT_B;
				ST_FILT_B:     state_q <= ST_FILT_SUM_A;
				ST_FILT_SUM_A: state_q <= ST_FILT_SUM_B;
				ST_FILT_SUM_B: state_q <= ST_FILT_ADD;
				ST_FILT_ADD:   state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default:       state_q <= ST_IDLE;
			endcase
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_ERR)
		else $error("An accepted transfer did not start the error step.");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("A result was raised outside the final step.");

	a_fin_completes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && fin_go |=> state_q == ST_IDLE && out_valid_q)
		else $error("The final step did not hand over its result.");

endmodule

// File: rtl/core/clamped_pid_with_filtered_derivative.sv
// The block takes a new input transfer only when idle, after it has finished with
// the last one. Its products go in sequence through the single shared 32x24
// multiplier, and filtered derivative mode takes more steps than plain mode.
// Reset clears the configuration registers, the integral, the previous error
// and the previous derivative term; the block is ready at once after reset.
module clamped_pid_with_filtered_derivative
	import cpid_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [31:0]        target,
	input  logic signed [31:0]        measured,
	input  logic                      clear_history,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [31:0]        drive,
	output logic                      output_saturated,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [CFG_DATA_WIDTH-1:0] pwdata,
	output logic [CFG_DATA_WIDTH-1:0] prdata,
	output logic                      pready
);

	cfg_t cfg;
	cmd_t cmd;

	cpid_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cpid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.filter_on (cfg.deriv_filter_on),
		.cmd       (cmd)
	);

	cpid_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.cmd              (cmd),
		.target           (target),
		.measured         (measured),
		.clear_history    (clear_history),
		.drive            (drive),
		.output_saturated (output_saturated)
	);

endmodule
